// File: rtl/core/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

    // Position of the next byte within its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Number of character slots in the output queue.
    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One output character with its flags.
    typedef struct packed {
        logic [6:0] code_char;
        logic       run_last;
        logic       message_end;
    } b64e_char_t;

    // The one or two characters that a single byte produces.
    typedef struct packed {
        logic       two;
        b64e_char_t first;
        b64e_char_t second;
    } b64e_pair_t;

    // Maps a six-bit value onto the standard base64 alphabet.
    function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
        logic [6:0] c;
        begin
            if (v < 6'd26) begin
                c = 7'd65 + {1'b0, v};
            end
            else if (v < 6'd52) begin
                c = 7'd71 + {1'b0, v};
            end
            else if (v < 6'd62) begin
                c = {1'b0, v} - 7'd4;
            end
            else if (v == 6'd62) begin
                c = 7'd43;
            end
            else begin
                c = 7'd47;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64e_channels.sv
`default_nettype none

// Byte channel into the encoder.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
    modport monitor (input valid, input data_byte, input final_byte, input ready);
endinterface

// Character channel out of the encoder.
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output code_char, output run_last,
                    output message_end, input ready);
    modport sink (input valid, input code_char, input run_last,
                  input message_end, output ready);
    modport monitor (input valid, input code_char, input run_last,
                     input message_end, input ready);
endinterface

`default_nettype wire

// File: rtl/core/b64e_encode.sv
`default_nettype none

module b64e_encode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       data_byte,
    input  wire logic             final_byte,
    output b64e_pkg::b64e_pair_t  pair
);
    import b64e_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       two;

    always_comb
    begin
        case (phase_reg)
            PHASE_SECOND:
            begin
                sextet0       = {leftover_reg[1:0], data_byte[7:4]};
                sextet1       = {data_byte[3:0], 2'b00};
                two           = final_byte;
                leftover_next = data_byte[3:0];
                phase_next    = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                sextet0       = {leftover_reg, data_byte[7:6]};
                sextet1       = data_byte[5:0];
                two           = 1'b1;
                leftover_next = 4'd0;
                phase_next    = PHASE_FIRST;
            end
            default:
            begin
                sextet0       = data_byte[7:2];
                sextet1       = {data_byte[1:0], 4'b0000};
                two           = final_byte;
                leftover_next = {2'b00, data_byte[1:0]};
                phase_next    = PHASE_SECOND;
            end
        endcase
        // A message end always starts the next byte on a fresh group.
        if (final_byte)
        begin
            leftover_next = 4'd0;
            phase_next    = PHASE_FIRST;
        end
    end

    always_comb
    begin
        pair.two                = two;
        pair.first.code_char    = sextet_to_char(sextet0);
        pair.first.run_last     = !two;
        pair.first.message_end  = !two && final_byte;
        pair.second.code_char   = sextet_to_char(sextet1);
        pair.second.run_last    = 1'b1;
        pair.second.message_end = final_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            leftover_reg <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64e_queue.sv
`default_nettype none

module b64e_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire b64e_pkg::b64e_pair_t pair,
    output logic                  space,
    output logic                  head_valid,
    input  wire logic             head_ready,
    output b64e_pkg::b64e_char_t  head
);
    import b64e_pkg::*;

    b64e_char_t               slot_reg [QUEUE_DEPTH];
    b64e_char_t               slot_next [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic [QUEUE_CNT_W-1:0]   base;
    logic [QUEUE_CNT_W-1:0]   added;
    logic                     take;

    // Room for two more characters is guaranteed while at most one is held.
    assign space      = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[0];
    assign take       = head_valid && head_ready;
    assign base       = count_reg - QUEUE_CNT_W'(take);
    assign added      = push ? (pair.two ? QUEUE_CNT_W'(2) : QUEUE_CNT_W'(1)) : '0;
    assign count_next = base + added;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (take)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push && (base == QUEUE_CNT_W'(i)))
            begin
                slot_next[i] = pair.first;
            end
            if (push && pair.two && ((base + QUEUE_CNT_W'(1)) == QUEUE_CNT_W'(i)))
            begin
                slot_next[i] = pair.second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/base64_stream_encoder.sv
`default_nettype none

// Channel  Modport  Word contents                              Direction
// bytes    sink     data_byte[7:0], final_byte                 into the encoder
// chars    source   code_char[6:0], run_last, message_end      out of the encoder
//
// A byte yields two characters if it is the third byte of a group or a final
// byte with bits left over, and one character otherwise; the character port
// moves one word per cycle while chars.ready is high.
// From an empty queue, a byte's first character is on chars in the next cycle.
// Reset is asynchronous and active low; it empties the output queue and
// returns the group position and kept bits to zero.
// A stalled character port fills a three-entry queue; bytes are refused only
// when fewer than two free entries remain.
module base64_stream_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64e_byte_if.sink   bytes,
    b64e_char_if.source chars
);
    import b64e_pkg::*;

    b64e_pair_t pair;
    b64e_char_t head;
    logic       space;
    logic       fire;

    // A byte is taken whenever the queue can hold everything it might produce,
    // so the byte side keeps moving while an earlier character is waiting.
    assign bytes.ready = space;
    assign fire        = bytes.valid && space;

    // Group position, kept bits and the sextet-to-alphabet mapping.
    b64e_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (bytes.data_byte),
        .final_byte (bytes.final_byte),
        .pair       (pair)
    );

    // Registered output queue; the head entry drives the character port.
    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .pair       (pair),
        .space      (space),
        .head_valid (chars.valid),
        .head_ready (chars.ready),
        .head       (head)
    );

    assign chars.code_char   = head.code_char;
    assign chars.run_last    = head.run_last;
    assign chars.message_end = head.message_end;

endmodule

`default_nettype wire

// File: rtl/core/b64e_checker.sv
`default_nettype none

module b64e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       byte_valid,
    input wire logic       byte_ready,
    input wire logic       byte_final,
    input wire logic       char_valid,
    input wire logic       char_ready,
    input wire logic [6:0] char_code,
    input wire logic       char_run_last,
    input wire logic       char_message_end
);

    // A stalled character holds still until it is taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_code)
            && $stable(char_run_last) && $stable(char_message_end))
        else $error("character changed while stalled");

    // The end of a message is always the last character of its byte.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_message_end |-> char_run_last)
        else $error("message_end without run_last");

    // A byte taken with the output empty shows a character in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !char_valid |=> char_valid)
        else $error("accepted byte produced no character");

    // The first character of a byte that does not end the message cannot end it.
    a_no_early_end: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !byte_final && !char_valid
            |=> !char_message_end)
        else $error("message_end on a byte that is not final");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_valid       (bytes.valid),
    .byte_ready       (bytes.ready),
    .byte_final       (bytes.final_byte),
    .char_valid       (chars.valid),
    .char_ready       (chars.ready),
    .char_code        (chars.code_char),
    .char_run_last    (chars.run_last),
    .char_message_end (chars.message_end)
);

`default_nettype wire
